>>> rtl/mrc_pkg.sv
// Shared types, function codes and constants for the Modbus response checker.
package mrc_pkg;

   // Widths of the configuration registers and of the stream words.
   localparam int HeaderWidth   = 3;
   localparam int ChecksumWidth = 2;
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = 3;
   localparam int ReqDataWidth  = 120;
   localparam int RspDataWidth  = 32;

   // Reset values of the configuration registers.
   localparam logic [HeaderWidth-1:0]   HeaderReset   = 3'd7;
   localparam logic [ChecksumWidth-1:0] ChecksumReset = 2'd0;
   localparam logic                     TcpModeReset  = 1'b1;

   // Register indexes on the configuration port.
   localparam logic [CsrIndexWidth-1:0] CSR_HEADER   = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_CHECKSUM = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_TCP_MODE = 2'd2;

   // Modbus function codes that change the length or count rules.
   localparam logic [7:0] FC_RD_COILS       = 8'd1;
   localparam logic [7:0] FC_RD_DISCRETE    = 8'd2;
   localparam logic [7:0] FC_RD_HOLDING     = 8'd3;
   localparam logic [7:0] FC_RD_INPUT       = 8'd4;
   localparam logic [7:0] FC_RD_EXC_STATUS  = 8'd7;
   localparam logic [7:0] FC_WR_MULTI_COILS = 8'd15;
   localparam logic [7:0] FC_WR_MULTI_REGS  = 8'd16;
   localparam logic [7:0] FC_REPORT_ID      = 8'd17;
   localparam logic [7:0] FC_MASK_WRITE     = 8'd22;
   localparam logic [7:0] FC_WR_RD_REGS     = 8'd23;

   // Fixed body lengths of the short responses.
   localparam logic [17:0] BodyExcStatus = 18'd3;
   localparam logic [17:0] BodyMaskWrite = 18'd7;
   localparam logic [17:0] BodyDefault   = 18'd5;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_OK  = 2'd0,
      ST_BAD = 2'd1,
      ST_EXC = 2'd2
   } status_type;

   // Input word; the last member sits in the lowest bits of tdata.
   typedef struct packed {
      logic [15:0] rsp_frame_length;
      logic [15:0] rsp_quantity;
      logic [7:0]  rsp_first_byte;
      logic [7:0]  rsp_code;
      logic [15:0] req_quantity;
      logic [7:0]  req_code;
      logic [15:0] rsp_protocol;
      logic [15:0] rsp_transaction;
      logic [15:0] req_transaction;
   } req_fields_type;

   // Result word without its padding; the last member sits lowest.
   typedef struct packed {
      logic [7:0]  exception_value;
      logic [15:0] value_count;
      status_type  status;
   } rsp_fields_type;

endpackage

>>> rtl/modbus_response_checker.sv
// Top level of the Modbus response checker: one request/response header pair in, one verdict out.
//
// Each input word on the req_ channel carries the header fields of one Modbus
// request and of the response that came back for it. The block checks the
// transaction and protocol identifiers (in TCP mode), the received length
// against the length expected from the request, the function code and the
// value count, and returns one result word on the rsp_ channel: a status, the
// confirmed value count and the exception code of an exception response.
//
// An accepted input word is held in the input register, and its result word in
// the result register, with the check logic between them.
// Throughput is one word per cycle while the result side takes its words. While
// rsp_tready is low a waiting result word holds still, and req_tready falls
// only once both stages hold a word.
//
// Reset empties both stages and restores header_bytes to 7, checksum_bytes
// to 0 and tcp_mode to 1. The csr_ port writes a register at any clock edge
// with csr_we high; an index beyond the register list is ignored.
module modbus_response_checker
   import mrc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // Configuration write port.
   input  logic                     csr_we,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_data,
   // Input words.
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // req_transaction, rsp_transaction, rsp_protocol, req_code, req_quantity,
   // rsp_code, rsp_first_byte, rsp_quantity, rsp_frame_length (lowest first)
   input  logic [ReqDataWidth-1:0]  req_tdata,
   // Result words.
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // status, value_count, exception_value, six zero bits (lowest first)
   output logic [RspDataWidth-1:0]  rsp_tdata
);

   localparam int PadWidth = RspDataWidth - $bits(rsp_fields_type);

   // Configuration registers.
   logic [HeaderWidth-1:0]   header_ff;
   logic [ChecksumWidth-1:0] checksum_ff;
   logic                     tcp_mode_ff;

   // Pipeline registers.
   logic           in_valid_ff;
   req_fields_type in_word_ff;
   logic           out_valid_ff;
   rsp_fields_type out_word_ff;
   rsp_fields_type out_word_in;

   // Handshake: the result register frees when empty or being taken.
   logic advance;

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff   <= HeaderReset;
         checksum_ff <= ChecksumReset;
         tcp_mode_ff <= TcpModeReset;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_HEADER:   header_ff   <= csr_data[HeaderWidth-1:0];
            CSR_CHECKSUM: checksum_ff <= csr_data[ChecksumWidth-1:0];
            CSR_TCP_MODE: tcp_mode_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Check logic between the input register and the result register.
   always_comb begin
      logic [16:0] coil_sum;
      logic [13:0] coil_bytes;
      logic [17:0] body;
      logic        len_known;
      logic [17:0] expected_len;
      logic [4:0]  exc_len;
      logic        id_bad;
      logic        counts_match;
      logic [15:0] count;

      coil_sum   = {1'b0, in_word_ff.req_quantity} + 17'd7;
      coil_bytes = coil_sum[16:3];
      len_known  = 1'b1;

      // Expected body length from the request code.
      case (in_word_ff.req_code) inside
         FC_RD_COILS, FC_RD_DISCRETE:
            body = 18'd2 + {4'b0, coil_bytes};
         FC_RD_HOLDING, FC_RD_INPUT, FC_WR_RD_REGS:
            body = 18'd2 + {1'b0, in_word_ff.req_quantity, 1'b0};
         FC_RD_EXC_STATUS: body = BodyExcStatus;
         FC_REPORT_ID: begin
            body      = '0;
            len_known = 1'b0;
         end
         FC_MASK_WRITE: body = BodyMaskWrite;
         default:       body = BodyDefault;
      endcase

      expected_len = {15'b0, header_ff} + body + {16'b0, checksum_ff};
      exc_len      = 5'd2 + {2'b0, header_ff} + {3'b0, checksum_ff};

      // Value counts of request and response for each function code.
      case (in_word_ff.rsp_code) inside
         FC_RD_COILS, FC_RD_DISCRETE: begin
            counts_match = coil_bytes == {6'b0, in_word_ff.rsp_first_byte};
            count        = {8'b0, in_word_ff.rsp_first_byte};
         end
         FC_RD_HOLDING, FC_RD_INPUT, FC_WR_RD_REGS: begin
            counts_match = in_word_ff.req_quantity ==
                           {9'b0, in_word_ff.rsp_first_byte[7:1]};
            count        = {9'b0, in_word_ff.rsp_first_byte[7:1]};
         end
         FC_WR_MULTI_COILS, FC_WR_MULTI_REGS: begin
            counts_match = in_word_ff.req_quantity == in_word_ff.rsp_quantity;
            count        = in_word_ff.rsp_quantity;
         end
         FC_REPORT_ID: begin
            counts_match = 1'b1;
            count        = {8'b0, in_word_ff.rsp_first_byte};
         end
         default: begin
            counts_match = 1'b1;
            count        = 16'd1;
         end
      endcase

      id_bad = tcp_mode_ff &&
               (in_word_ff.req_transaction != in_word_ff.rsp_transaction ||
                in_word_ff.rsp_protocol != 16'd0);

      // Verdict, in the order the checks take precedence.
      out_word_in.status          = ST_BAD;
      out_word_in.value_count     = '0;
      out_word_in.exception_value = '0;
      if (id_bad) begin
         out_word_in.status = ST_BAD;
      end else if (in_word_ff.rsp_code[7]) begin
         // Exception response: fixed length and the request code with bit 7 set.
         if (in_word_ff.rsp_frame_length == {11'b0, exc_len} &&
             in_word_ff.req_code == {1'b0, in_word_ff.rsp_code[6:0]}) begin
            out_word_in.status          = ST_EXC;
            out_word_in.exception_value = in_word_ff.rsp_first_byte;
         end
      end else if (len_known && {2'b0, in_word_ff.rsp_frame_length} != expected_len) begin
         out_word_in.status = ST_BAD;
      end else if (in_word_ff.rsp_code != in_word_ff.req_code) begin
         out_word_in.status = ST_BAD;
      end else if (counts_match) begin
         out_word_in.status      = ST_OK;
         out_word_in.value_count = count;
      end
   end

   // Pipeline control.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_word_ff <= req_fields_type'(req_tdata);
      end
      if (advance && in_valid_ff) begin
         out_word_ff <= out_word_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{PadWidth{1'b0}}, out_word_ff};

endmodule

>>> rtl/mrc_checker.sv
// Port-level checks on the result channel of the Modbus response checker, bound to the top level.
module mrc_checker
   import mrc_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_tvalid,
   input logic                    rsp_tready,
   input logic [RspDataWidth-1:0] rsp_tdata
);

   // A result word waiting for the receiver holds still.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("Stalled result word changed.");

   // Only the three defined status codes appear, and the padding stays clear.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[1:0] == ST_OK || rsp_tdata[1:0] == ST_BAD ||
                      rsp_tdata[1:0] == ST_EXC) && rsp_tdata[31:26] == 6'd0)
      else $error("Undefined status or padding in result word.");

   // A value count is reported only with an ok status.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != ST_OK |-> rsp_tdata[17:2] == 16'd0)
      else $error("Value count present without ok status.");

   // An exception code is reported only with an exception status.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != ST_EXC |-> rsp_tdata[25:18] == 8'd0)
      else $error("Exception code present without exception status.");

endmodule

bind modbus_response_checker mrc_checker u_mrc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> test/testbench.sv
// Self-checking testbench for the Modbus response checker, with a scoreboard class and stream drivers.
module testbench;
   import mrc_pkg::*;

   // Function codes at and above this value mark an exception response.
   localparam int unsigned ExceptionFlag = 'h80;
   // Idle chance per cycle, in percent, on both sides of the block.
   localparam int unsigned IdlePercent = 35;
   // Random words sent under each register setting.
   localparam int PhaseWords = 100;
   localparam int PhaseCount = 7;

   // Ways in which a generated exchange departs from a well-formed one.
   typedef enum int {
      SP_NONE,
      SP_EXCEPTION,
      SP_EXC_LENGTH,
      SP_EXC_CODE,
      SP_TRANS,
      SP_PROTO,
      SP_LENGTH,
      SP_CODE,
      SP_COUNT,
      SP_NOISE
   } shape_type;

   // Scoreboard: predicts the verdict for each accepted word and checks results in order.
   class verdict_board;
      rsp_fields_type verdict_q[$];
      bit [2:0] hdr;
      bit [1:0] chk;
      bit       tcp;
      int       n_checked;
      int       n_err;
      int       by_status[3];

      function new();
         hdr = HeaderReset;
         chk = ChecksumReset;
         tcp = TcpModeReset;
      endfunction

      // Mirrors a register write; indexes beyond the list change nothing.
      function void set_reg(logic [CsrIndexWidth-1:0] idx, logic [CsrDataWidth-1:0] d);
         case (idx)
            CSR_HEADER:   hdr = d[2:0];
            CSR_CHECKSUM: chk = d[1:0];
            CSR_TCP_MODE: tcp = d[0];
            default:      ;
         endcase
      endfunction

      // Works out the verdict for one request/response header pair.
      function rsp_fields_type judge(req_fields_type f);
         rsp_fields_type r;
         int unsigned body, len, rqq, rqc, rsc, rfb, rsq, frame, req_n, rsp_n;
         bit len_known;
         r.status = ST_BAD;
         r.value_count = '0;
         r.exception_value = '0;
         rqq = f.req_quantity;
         rqc = f.req_code;
         rsc = f.rsp_code;
         rfb = f.rsp_first_byte;
         rsq = f.rsp_quantity;
         frame = hdr + chk;
         len = f.rsp_frame_length;
         len_known = 1'b1;
         // Identifier checks come first in TCP mode.
         if (tcp && (f.req_transaction != f.rsp_transaction || f.rsp_protocol != 0))
            return r;
         case (f.req_code)
            FC_RD_COILS, FC_RD_DISCRETE:              body = 2 + (rqq + 7) / 8;
            FC_RD_HOLDING, FC_RD_INPUT, FC_WR_RD_REGS: body = 2 + 2 * rqq;
            FC_RD_EXC_STATUS:                         body = 3;
            FC_MASK_WRITE:                            body = 7;
            FC_REPORT_ID: begin
               body = 0;
               len_known = 1'b0;
            end
            default:                                  body = 5;
         endcase
         // An exception response must be short and echo the request code.
         if (rsc >= ExceptionFlag) begin
            if (len == frame + 2 && rqc == rsc - ExceptionFlag) begin
               r.status = ST_EXC;
               r.exception_value = f.rsp_first_byte;
            end
            return r;
         end
         if (len_known && len != frame + body)
            return r;
         if (rsc != rqc)
            return r;
         case (f.rsp_code)
            FC_RD_COILS, FC_RD_DISCRETE: begin
               req_n = (rqq + 7) / 8;
               rsp_n = rfb;
            end
            FC_RD_HOLDING, FC_RD_INPUT, FC_WR_RD_REGS: begin
               req_n = rqq;
               rsp_n = rfb / 2;
            end
            FC_WR_MULTI_COILS, FC_WR_MULTI_REGS: begin
               req_n = rqq;
               rsp_n = rsq;
            end
            FC_REPORT_ID: begin
               req_n = rfb;
               rsp_n = rfb;
            end
            default: begin
               req_n = 1;
               rsp_n = 1;
            end
         endcase
         if (req_n == rsp_n) begin
            r.status = ST_OK;
            r.value_count = rsp_n[15:0];
         end
         return r;
      endfunction

      function void note_word(req_fields_type f);
         verdict_q.push_back(judge(f));
      endfunction

      // Compares one result word with the oldest verdict waiting.
      function void check_word(logic [RspDataWidth-1:0] w);
         rsp_fields_type got, want;
         got = w[$bits(rsp_fields_type)-1:0];
         if (verdict_q.size() == 0) begin
            $error("result word %h arrived with no verdict waiting", w);
            n_err++;
            return;
         end
         want = verdict_q.pop_front();
         n_checked++;
         by_status[want.status]++;
         if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            n_err++;
         end
         if (got.value_count !== want.value_count) begin
            $error("value_count: expected %0d, actual %0d", want.value_count, got.value_count);
            n_err++;
         end
         if (got.exception_value !== want.exception_value) begin
            $error("exception_value: expected %0d, actual %0d",
                   want.exception_value, got.exception_value);
            n_err++;
         end
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_we = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0]  csr_data = '0;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [ReqDataWidth-1:0]  req_tdata = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RspDataWidth-1:0]  rsp_tdata;

   verdict_board sb = new();
   bit           steady = 1'b0;
   int           n_sent = 0;

   modbus_response_checker dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #4 clock = ~clock;

   // The result side stalls at random except during the steady stretch.
   always @(negedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= IdlePercent);
   end

   // Every result word accepted is checked against the scoreboard.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready)
         sb.check_word(rsp_tdata);
   end

   // Generous time limit for a hung run.
   initial begin
      #4_000_000;
      $display("testbench: FAIL");
      $finish;
   end

   function automatic logic [7:0] code_of(int k);
      case (k)
         0:       return FC_RD_COILS;
         1:       return FC_RD_DISCRETE;
         2:       return FC_RD_HOLDING;
         3:       return FC_RD_INPUT;
         4:       return FC_RD_EXC_STATUS;
         5:       return FC_WR_MULTI_COILS;
         6:       return FC_WR_MULTI_REGS;
         7:       return FC_REPORT_ID;
         8:       return FC_MASK_WRITE;
         9:       return FC_WR_RD_REGS;
         default: return 8'($urandom_range(127));
      endcase
   endfunction

   // Builds a consistent exchange for the current registers, then spoils it as asked.
   function automatic req_fields_type build(shape_type shape, logic [7:0] code);
      req_fields_type f;
      int unsigned q, frame, len;
      frame = sb.hdr + sb.chk;
      f.req_transaction  = 16'($urandom);
      f.rsp_transaction  = 16'($urandom);
      f.rsp_protocol     = 16'($urandom);
      f.req_code         = 8'($urandom);
      f.req_quantity     = 16'($urandom);
      f.rsp_code         = 8'($urandom);
      f.rsp_first_byte   = 8'($urandom);
      f.rsp_quantity     = 16'($urandom);
      f.rsp_frame_length = 16'($urandom);
      if (shape == SP_NOISE)
         return f;
      f.rsp_transaction = f.req_transaction;
      f.rsp_protocol = '0;
      f.req_code = code;
      f.rsp_code = code;
      case (code)
         FC_RD_COILS, FC_RD_DISCRETE: begin
            q = ($urandom_range(3) == 0) ? $urandom_range(2040) : $urandom_range(40);
            f.req_quantity = 16'(q);
            f.rsp_first_byte = 8'((q + 7) / 8);
            len = frame + 2 + (q + 7) / 8;
         end
         FC_RD_HOLDING, FC_RD_INPUT, FC_WR_RD_REGS: begin
            q = $urandom_range(127);
            f.req_quantity = 16'(q);
            // An odd byte count still rounds down to the requested count.
            f.rsp_first_byte = 8'(2 * q + $urandom_range(1));
            len = frame + 2 + 2 * q;
         end
         FC_RD_EXC_STATUS: len = frame + 3;
         FC_MASK_WRITE:    len = frame + 7;
         FC_WR_MULTI_COILS, FC_WR_MULTI_REGS: begin
            f.rsp_quantity = f.req_quantity;
            len = frame + 5;
         end
         FC_REPORT_ID:     len = $urandom_range(300);
         default:          len = frame + 5;
      endcase
      f.rsp_frame_length = 16'(len);
      if (shape == SP_EXCEPTION || shape == SP_EXC_LENGTH || shape == SP_EXC_CODE) begin
         f.rsp_code = code | 8'(ExceptionFlag);
         f.rsp_frame_length = 16'(frame + 2);
      end
      case (shape)
         SP_EXC_LENGTH: f.rsp_frame_length = 16'(frame + 3 + $urandom_range(3));
         SP_EXC_CODE:   f.rsp_code = f.rsp_code ^ 8'(1 << $urandom_range(6));
         SP_TRANS:      f.rsp_transaction = f.rsp_transaction ^ 16'(1 << $urandom_range(15));
         SP_PROTO:      f.rsp_protocol = 16'($urandom_range(65535, 1));
         SP_LENGTH:     f.rsp_frame_length = $urandom_range(1) ? f.rsp_frame_length + 16'd1
                                                               : f.rsp_frame_length - 16'd1;
         SP_CODE:       f.rsp_code = code ^ 8'(1 << $urandom_range(6));
         SP_COUNT: begin
            case (code)
               FC_RD_COILS, FC_RD_DISCRETE:
                  f.rsp_first_byte = f.rsp_first_byte + 8'(1 + $urandom_range(3));
               FC_RD_HOLDING, FC_RD_INPUT, FC_WR_RD_REGS:
                  f.rsp_first_byte = f.rsp_first_byte + 8'd2;
               FC_WR_MULTI_COILS, FC_WR_MULTI_REGS:
                  f.rsp_quantity = f.rsp_quantity ^ 16'(1 << $urandom_range(15));
               default: ;
            endcase
         end
         default: ;
      endcase
      return f;
   endfunction

   // Mostly well-formed exchanges, with a share of spoiled ones and noise.
   function automatic req_fields_type random_word();
      int unsigned r;
      shape_type shape;
      r = $urandom_range(99);
      if (r < 55)      shape = SP_NONE;
      else if (r < 62) shape = SP_EXCEPTION;
      else if (r < 65) shape = SP_EXC_LENGTH;
      else if (r < 68) shape = SP_EXC_CODE;
      else if (r < 73) shape = SP_TRANS;
      else if (r < 78) shape = SP_PROTO;
      else if (r < 84) shape = SP_LENGTH;
      else if (r < 89) shape = SP_CODE;
      else if (r < 95) shape = SP_COUNT;
      else             shape = SP_NOISE;
      return build(shape, code_of($urandom_range(10)));
   endfunction

   // Offers one word after a random idle gap; returns at the falling edge after acceptance.
   task automatic send_word(req_fields_type f);
      while (!steady && $urandom_range(99) < IdlePercent) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= f;
      do
         @(posedge clock);
      while (!req_tready);
      sb.note_word(f);
      n_sent++;
      @(negedge clock);
   endtask

   // Stops sending and waits until every verdict has been matched.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.verdict_q.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(logic [CsrIndexWidth-1:0] idx, logic [CsrDataWidth-1:0] d);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= d;
      sb.set_reg(idx, d);
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Register settings per phase; the extremes of every register appear.
   int unsigned hdr_set [PhaseCount] = '{0, 7, 1, 3, 7, 5, 2};
   int unsigned chk_set [PhaseCount] = '{0, 3, 2, 1, 0, 3, 2};
   int unsigned tcp_set [PhaseCount] = '{0, 1, 0, 1, 1, 0, 1};

   initial begin
      req_fields_type f;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      repeat (2) @(negedge clock);

      // Directed part under the reset register values.
      f = '0;
      send_word(f);
      f = '1;
      send_word(f);
      for (int k = 0; k < 10; k++)
         send_word(build(SP_NONE, code_of(k)));
      for (int s = SP_EXCEPTION; s <= SP_NOISE; s++)
         send_word(build(shape_type'(s), code_of($urandom_range(10))));

      // Random part, one register setting per phase.
      for (int p = 0; p < PhaseCount; p++) begin
         settle();
         csr_write(CSR_HEADER, 3'(hdr_set[p]));
         csr_write(CSR_CHECKSUM, 3'(chk_set[p]) | 3'($urandom_range(1) << 2));
         csr_write(CSR_TCP_MODE, {2'($urandom_range(3)), 1'(tcp_set[p])});
         // The index past the register list must leave everything alone.
         csr_write(CsrIndexWidth'(3), 3'($urandom));
         steady = (p == 4);
         for (int i = 0; i < PhaseWords; i++) begin
            if (p == 2 && i == PhaseWords / 2)
               settle();
            send_word(random_word());
         end
      end
      steady = 1'b0;
      settle();
      repeat (10) @(negedge clock);

      $display("testbench: %0d words sent, %0d verdicts checked over %0d register settings",
               n_sent, sb.n_checked, PhaseCount + 1);
      $display("testbench: verdicts seen: %0d ok, %0d bad data, %0d exception",
               sb.by_status[ST_OK], sb.by_status[ST_BAD], sb.by_status[ST_EXC]);
      if (sb.n_err == 0 && sb.verdict_q.size() == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule

>>> sim.f
rtl/mrc_pkg.sv
rtl/modbus_response_checker.sv
rtl/mrc_checker.sv
test/testbench.sv
